### hw/rtl/hckc_pkg.sv
package hckc_pkg;

  // field widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned HUE_W  = 9;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CFG_W  = 9;
  localparam int unsigned IDX_W  = 3;

  // quotient steps per divider (hue < 360 and saturation <= 100 both fit)
  localparam int unsigned DIV_Q  = 9;
  // hue numerator: below 360 * 255
  localparam int unsigned NUM_W  = 17;
  // saturation numerator: 100 * d
  localparam int unsigned SDV_W  = 15;

  // pipeline: front, numerator, divider steps, output
  localparam int unsigned NSTG   = DIV_Q + 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_HUE_CENTER    = 3'd0;
  localparam logic [IDX_W-1:0] REG_HUE_HALFWIDTH = 3'd1;
  localparam logic [IDX_W-1:0] REG_SAT_CENTER    = 3'd2;
  localparam logic [IDX_W-1:0] REG_SAT_HALFWIDTH = 3'd3;
  localparam logic [IDX_W-1:0] REG_VAL_CENTER    = 3'd4;
  localparam logic [IDX_W-1:0] REG_VAL_HALFWIDTH = 3'd5;

  // register reset values
  localparam logic [HUE_W-1:0] HUE_CENTER_RST    = 9'd120;
  localparam logic [HUE_W-1:0] HUE_HALFWIDTH_RST = 9'd30;
  localparam logic [PCT_W-1:0] SAT_CENTER_RST    = 7'd50;
  localparam logic [PCT_W-1:0] SAT_HALFWIDTH_RST = 7'd20;
  localparam logic [PCT_W-1:0] VAL_CENTER_RST    = 7'd50;
  localparam logic [PCT_W-1:0] VAL_HALFWIDTH_RST = 7'd20;

  // hue sector offsets and slope
  localparam logic [NUM_W-1:0] HUE_SLOPE  = 17'd60;
  localparam logic [NUM_W-1:0] OFS_GREEN  = 17'd120;
  localparam logic [NUM_W-1:0] OFS_BLUE   = 17'd240;
  localparam logic [NUM_W-1:0] OFS_WRAP   = 17'd360;

  // floor(100 * mx / 255) as (mx * ceil(100 * 2^23 / 255)) >> 23
  localparam int unsigned      VAL_SHIFT  = 23;
  localparam int unsigned      VAL_PROD_W = 30;
  localparam logic [VAL_PROD_W-1:0] VAL_RECIP = 30'd3289651;

  localparam logic [PCT_W-1:0] PCT_MAX    = 7'd99;

  // value thresholds on the maximum channel
  localparam logic [PIX_W-1:0] MX_HALF    = 8'd128;  // mx/255 > 0.5
  localparam logic [PIX_W-1:0] MX_BRIGHT  = 8'd204;  // mx/255 > 0.8 when mx above this
  localparam logic [PIX_W-1:0] MX_DIM     = 8'd38;   // mx/255 > 0.15 when mx above this

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  // per-pixel flags that ride beside the dividers
  typedef struct packed {
    logic             hue_zero;
    logic             sat_low;     // saturation <= 0.65
    logic             sat_high;    // saturation > 0.7
    logic             val_half;    // value > 0.5
    logic             val_bright;  // value > 0.8
    logic             val_dim_ok;  // value > 0.15
    logic [PCT_W-1:0] val_pct;
  } side_t;

endpackage

### hw/rtl/hckc_div.sv
module hckc_div #(
  parameter int unsigned DW = 17,
  parameter int unsigned VW = 8,
  parameter int unsigned QW = 9
) (
  input  logic          clk,
  input  logic [QW-1:0] en,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [QW-1:0] quotient
);

  localparam int unsigned CW = (DW > VW + QW) ? DW : VW + QW;

  logic [DW-1:0] rem [QW];
  logic [VW-1:0] dvs [QW];
  logic [QW-1:0] quo [QW];

  // one restoring quotient bit per stage, msb first
  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [VW-1:0] dvs_in;
    logic [QW-1:0] quo_in;
    logic [CW-1:0] trial;
    logic          fit;

    if (j == 0) begin : g_first
      assign rem_in = dividend;
      assign dvs_in = divisor;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem[j-1];
      assign dvs_in = dvs[j-1];
      assign quo_in = quo[j-1];
    end

    assign trial = CW'(dvs_in) << (QW - 1 - j);
    assign fit   = CW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j] <= fit ? DW'(CW'(rem_in) - trial) : rem_in;
        dvs[j] <= dvs_in;
        quo[j] <= quo_in | (fit ? (QW'(1) << (QW - 1 - j)) : QW'(0));
      end
    end
  end

  assign quotient = quo[QW-1];

endmodule

### hw/rtl/hsv_chroma_key_classifier.sv
// RGB to HSV chroma keyer: takes one pixel per clock while the output is not
// stalled and returns floored hue in degrees, saturation and value percent
// (clamped at 99) and a background flag judged against the configured hue,
// saturation and value bands. The sustained rate is one pixel per cycle without
// output back-pressure; most of the depth comes from the two 9-stage restoring
// dividers (hue and saturation) that run side by side, one quotient bit per
// stage. Each stage holds its beat when the one after it is full, so bubbles close up under
// output back-pressure. Registers are written through the cfg port, which is
// always ready; write them only while no pixel is in flight. Writes to index 6
// or above are dropped.
module hsv_chroma_key_classifier (
  input  logic                             clk,
  input  logic                             rst,
  // pixel in
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hckc_pkg::PIX_W-1:0]       red,
  input  logic [hckc_pkg::PIX_W-1:0]       green,
  input  logic [hckc_pkg::PIX_W-1:0]       blue,
  // classification out
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             is_background,
  output logic [hckc_pkg::HUE_W-1:0]       hue_deg,
  output logic [hckc_pkg::PCT_W-1:0]       sat_pct,
  output logic [hckc_pkg::PCT_W-1:0]       val_pct,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hckc_pkg::IDX_W-1:0]       cfg_index,
  input  logic [hckc_pkg::CFG_W-1:0]       cfg_data
);

  localparam int unsigned NS = hckc_pkg::NSTG;
  localparam int unsigned DQ = hckc_pkg::DIV_Q;

  // configuration registers
  logic [hckc_pkg::HUE_W-1:0] hue_center;
  logic [hckc_pkg::HUE_W-1:0] hue_halfwidth;
  logic [hckc_pkg::PCT_W-1:0] sat_center;
  logic [hckc_pkg::PCT_W-1:0] sat_halfwidth;
  logic [hckc_pkg::PCT_W-1:0] val_center;
  logic [hckc_pkg::PCT_W-1:0] val_halfwidth;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_center    <= hckc_pkg::HUE_CENTER_RST;
      hue_halfwidth <= hckc_pkg::HUE_HALFWIDTH_RST;
      sat_center    <= hckc_pkg::SAT_CENTER_RST;
      sat_halfwidth <= hckc_pkg::SAT_HALFWIDTH_RST;
      val_center    <= hckc_pkg::VAL_CENTER_RST;
      val_halfwidth <= hckc_pkg::VAL_HALFWIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hckc_pkg::REG_HUE_CENTER:    hue_center    <= cfg_data;
        hckc_pkg::REG_HUE_HALFWIDTH: hue_halfwidth <= cfg_data;
        hckc_pkg::REG_SAT_CENTER:    sat_center    <= cfg_data[hckc_pkg::PCT_W-1:0];
        hckc_pkg::REG_SAT_HALFWIDTH: sat_halfwidth <= cfg_data[hckc_pkg::PCT_W-1:0];
        hckc_pkg::REG_VAL_CENTER:    val_center    <= cfg_data[hckc_pkg::PCT_W-1:0];
        hckc_pkg::REG_VAL_HALFWIDTH: val_halfwidth <= cfg_data[hckc_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage load enables
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 0: max, min, spread and the sector difference
  logic [hckc_pkg::PIX_W-1:0] mx_c, mn_c;
  hckc_pkg::max_sel_t         sel_c;
  logic signed [hckc_pkg::PIX_W:0] diff_c;

  always_comb begin
    mx_c = red;
    mn_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c)  mx_c = blue;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c)  mn_c = blue;
    if (mx_c == red) begin
      sel_c  = hckc_pkg::MAX_RED;
      diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (mx_c == green) begin
      sel_c  = hckc_pkg::MAX_GREEN;
      diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sel_c  = hckc_pkg::MAX_BLUE;
      diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  logic [hckc_pkg::PIX_W-1:0]      s0_mx, s0_d;
  hckc_pkg::max_sel_t              s0_sel;
  logic signed [hckc_pkg::PIX_W:0] s0_diff;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_mx   <= mx_c;
      s0_d    <= mx_c - mn_c;
      s0_sel  <= sel_c;
      s0_diff <= diff_c;
    end
  end

  // stage 1: hue numerator, divider operands and threshold flags
  logic [hckc_pkg::NUM_W-1:0]        ofs_c;
  logic signed [hckc_pkg::NUM_W+1:0] num_full_c;
  logic [hckc_pkg::NUM_W-1:0]        num_c;
  logic [hckc_pkg::VAL_PROD_W-1:0]   vprod_c;
  logic [hckc_pkg::PCT_W:0]          vraw_c;
  logic [12:0]                       d20_c, d10_c, mx13_c, mx7_c;
  hckc_pkg::side_t                   side_c;

  always_comb begin
    case (s0_sel)
      hckc_pkg::MAX_RED:
        ofs_c = s0_diff[hckc_pkg::PIX_W] ? hckc_pkg::NUM_W'(s0_d) * hckc_pkg::OFS_WRAP : '0;
      hckc_pkg::MAX_GREEN: ofs_c = hckc_pkg::NUM_W'(s0_d) * hckc_pkg::OFS_GREEN;
      hckc_pkg::MAX_BLUE:  ofs_c = hckc_pkg::NUM_W'(s0_d) * hckc_pkg::OFS_BLUE;
      default:             ofs_c = '0;
    endcase
    num_full_c = (hckc_pkg::NUM_W + 2)'(s0_diff) *
                 $signed({2'b00, hckc_pkg::HUE_SLOPE}) + $signed({2'b00, ofs_c});
    num_c  = num_full_c[hckc_pkg::NUM_W-1:0];

    vprod_c = hckc_pkg::VAL_PROD_W'(s0_mx) * hckc_pkg::VAL_RECIP;
    vraw_c  = vprod_c[hckc_pkg::VAL_SHIFT +: hckc_pkg::PCT_W + 1];

    d20_c  = 13'(s0_d) * 13'd20;
    d10_c  = 13'(s0_d) * 13'd10;
    mx13_c = 13'(s0_mx) * 13'd13;
    mx7_c  = 13'(s0_mx) * 13'd7;

    side_c.hue_zero   = (num_c == '0);
    side_c.sat_low    = d20_c <= mx13_c;
    side_c.sat_high   = d10_c > mx7_c;
    side_c.val_half   = s0_mx >= hckc_pkg::MX_HALF;
    side_c.val_bright = s0_mx > hckc_pkg::MX_BRIGHT;
    side_c.val_dim_ok = s0_mx > hckc_pkg::MX_DIM;
    side_c.val_pct    = (vraw_c > (hckc_pkg::PCT_W + 1)'(hckc_pkg::PCT_MAX)) ?
                        hckc_pkg::PCT_MAX : vraw_c[hckc_pkg::PCT_W-1:0];
  end

  logic [hckc_pkg::NUM_W-1:0] s1_num;
  logic [hckc_pkg::PIX_W-1:0] s1_hdiv;
  logic [hckc_pkg::SDV_W-1:0] s1_sdvd;
  logic [hckc_pkg::PIX_W-1:0] s1_sdiv;
  hckc_pkg::side_t            s1_side;

  // a zero divisor only meets a zero dividend, so divide by one instead
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_num  <= num_c;
      s1_hdiv <= (s0_d == '0) ? hckc_pkg::PIX_W'(1) : s0_d;
      s1_sdvd <= hckc_pkg::SDV_W'(s0_d) * hckc_pkg::SDV_W'(100);
      s1_sdiv <= (s0_mx == '0) ? hckc_pkg::PIX_W'(1) : s0_mx;
      s1_side <= side_c;
    end
  end

  // stages 2 .. DQ+1: hue and saturation quotients
  logic [DQ-1:0] hue_q, sat_q;

  hckc_div #(
    .DW (hckc_pkg::NUM_W),
    .VW (hckc_pkg::PIX_W),
    .QW (DQ)
  ) u_hue_div (
    .clk      (clk),
    .en       (en[DQ+1:2]),
    .dividend (s1_num),
    .divisor  (s1_hdiv),
    .quotient (hue_q)
  );

  hckc_div #(
    .DW (hckc_pkg::SDV_W),
    .VW (hckc_pkg::PIX_W),
    .QW (DQ)
  ) u_sat_div (
    .clk      (clk),
    .en       (en[DQ+1:2]),
    .dividend (s1_sdvd),
    .divisor  (s1_sdiv),
    .quotient (sat_q)
  );

  // flags travel beside the dividers
  hckc_pkg::side_t side_pipe [DQ];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      side_pipe[0] <= s1_side;
    end
    for (int j = 1; j < DQ; j++) begin
      if (en[j+2]) begin
        side_pipe[j] <= side_pipe[j-1];
      end
    end
  end

  // output stage: band tests and keying rules
  logic [hckc_pkg::HUE_W-1:0]          hue_c;
  logic [hckc_pkg::PCT_W-1:0]          sat_c;
  logic signed [hckc_pkg::HUE_W+1:0]   hue_lo, hue_hi, hue_s;
  logic signed [hckc_pkg::PCT_W:0]     sat_fl, val_fl, sat_s, val_s;
  logic                                in_band, rule1, rule2, rule3;
  hckc_pkg::side_t                     sd;

  always_comb begin
    sd     = side_pipe[DQ-1];
    hue_c  = hue_q[hckc_pkg::HUE_W-1:0];
    sat_c  = (sat_q > DQ'(hckc_pkg::PCT_MAX)) ? hckc_pkg::PCT_MAX : sat_q[hckc_pkg::PCT_W-1:0];

    hue_lo = $signed({2'b00, hue_center}) - $signed({2'b00, hue_halfwidth});
    hue_hi = $signed({2'b00, hue_center}) + $signed({2'b00, hue_halfwidth});
    hue_s  = $signed({2'b00, hue_c});
    sat_fl = $signed({1'b0, sat_center}) - $signed({1'b0, sat_halfwidth});
    val_fl = $signed({1'b0, val_center}) - $signed({1'b0, val_halfwidth});
    sat_s  = $signed({1'b0, sat_c});
    val_s  = $signed({1'b0, sd.val_pct});

    in_band = (hue_s >= hue_lo) && (hue_s <= hue_hi);
    rule1   = in_band && (sat_s >= sat_fl) && (sd.val_half || (val_s >= val_fl));
    rule2   = (sd.hue_zero || in_band) && sd.sat_low && sd.val_bright;
    rule3   = in_band && sd.sat_high && sd.val_dim_ok;
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      is_background <= rule1 || rule2 || rule3;
      hue_deg       <= hue_c;
      sat_pct       <= sat_c;
      val_pct       <= sd.val_pct;
    end
  end

  assign out_valid = v[NS-1];

endmodule

### dv/hsv_chroma_key_classifier_test.sv
`timescale 1ns / 100ps

module hsv_chroma_key_classifier_test;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned BAND_PHASES      = 8;
  localparam int unsigned PIXELS_PER_PHASE = 72;
  localparam int unsigned DIRECTED_ROWS    = 24;
  localparam int unsigned TOTAL_PIXELS     = DIRECTED_ROWS + BAND_PHASES * PIXELS_PER_PHASE;

  // indexes past the register file, writes there must be dropped
  localparam logic [hckc_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [hckc_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                       is_bg;
    logic [hckc_pkg::HUE_W-1:0] hue;
    logic [hckc_pkg::PCT_W-1:0] sat;
    logic [hckc_pkg::PCT_W-1:0] val;
  } pixel_class_t;

  typedef struct packed {
    logic [hckc_pkg::PIX_W-1:0] r;
    logic [hckc_pkg::PIX_W-1:0] g;
    logic [hckc_pkg::PIX_W-1:0] b;
    logic                       typed;
    pixel_class_t               want;
  } pixel_row_t;

  // directed pixels under reset bands; typed rows carry their own answer
  pixel_row_t dir_rows [DIRECTED_ROWS] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{1'b0, 9'd0,   7'd0,  7'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{1'b1, 9'd0,   7'd0,  7'd99}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{1'b1, 9'd120, 7'd99, 7'd99}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{1'b0, 9'd0,   7'd99, 7'd99}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{1'b0, 9'd240, 7'd99, 7'd99}},
    '{8'd255, 8'd255, 8'd0,   1'b0, '0},
    '{8'd255, 8'd0,   8'd255, 1'b0, '0},
    '{8'd0,   8'd255, 8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd10,  1'b0, '0},
    '{8'd200, 8'd50,  8'd50,  1'b0, '0},
    '{8'd128, 8'd128, 8'd128, 1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd1,   8'd0,   1'b0, '0},
    '{8'd40,  8'd127, 8'd40,  1'b0, '0},
    '{8'd40,  8'd128, 8'd40,  1'b0, '0},
    '{8'd60,  8'd204, 8'd60,  1'b0, '0},
    '{8'd60,  8'd205, 8'd60,  1'b0, '0},
    '{8'd10,  8'd38,  8'd10,  1'b0, '0},
    '{8'd10,  8'd39,  8'd10,  1'b0, '0},
    '{8'd70,  8'd200, 8'd70,  1'b0, '0},
    '{8'd60,  8'd200, 8'd60,  1'b0, '0},
    '{8'd59,  8'd200, 8'd59,  1'b0, '0},
    '{8'd100, 8'd180, 8'd100, 1'b0, '0},
    '{8'd60,  8'd200, 8'd80,  1'b0, '0}
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [hckc_pkg::PIX_W-1:0] red = '0;
  logic [hckc_pkg::PIX_W-1:0] green = '0;
  logic [hckc_pkg::PIX_W-1:0] blue = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       is_background;
  logic [hckc_pkg::HUE_W-1:0] hue_deg;
  logic [hckc_pkg::PCT_W-1:0] sat_pct;
  logic [hckc_pkg::PCT_W-1:0] val_pct;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [hckc_pkg::IDX_W-1:0] cfg_index = '0;
  logic [hckc_pkg::CFG_W-1:0] cfg_data = '0;

  // typed answer that rides with the pixel beat
  logic                       typed_on = 1'b0;
  pixel_class_t               typed_class = '0;

  // local copy of the band registers
  logic [hckc_pkg::HUE_W-1:0] key_hue_center = hckc_pkg::HUE_CENTER_RST;
  logic [hckc_pkg::HUE_W-1:0] key_hue_half   = hckc_pkg::HUE_HALFWIDTH_RST;
  logic [hckc_pkg::PCT_W-1:0] key_sat_center = hckc_pkg::SAT_CENTER_RST;
  logic [hckc_pkg::PCT_W-1:0] key_sat_half   = hckc_pkg::SAT_HALFWIDTH_RST;
  logic [hckc_pkg::PCT_W-1:0] key_val_center = hckc_pkg::VAL_CENTER_RST;
  logic [hckc_pkg::PCT_W-1:0] key_val_half   = hckc_pkg::VAL_HALFWIDTH_RST;

  // expected results in send order, one slot per pixel of the run
  pixel_class_t     class_mem [TOTAL_PIXELS];
  int               class_wr = 0;
  int               class_rd = 0;
  pixel_class_t     want_class;
  int               mismatches = 0;
  int               pixels_seen = 0;
  int               keyed_seen = 0;
  int               cycle_count = 0;
  int               ready_hold = 0;
  bit               idle_on = 1'b1;

  hsv_chroma_key_classifier u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_background (is_background),
    .hue_deg       (hue_deg),
    .sat_pct       (sat_pct),
    .val_pct       (val_pct),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // hsv conversion and keying rules in exact integer arithmetic
  function automatic pixel_class_t classify_pixel(input logic [hckc_pkg::PIX_W-1:0] r8,
                                                  input logic [hckc_pkg::PIX_W-1:0] g8,
                                                  input logic [hckc_pkg::PIX_W-1:0] b8);
    int r, g, b, mx, mn, d, num, hue, sat, val;
    int hc, hh, sc, sh, vc, vh;
    logic hue_zero, in_band, rule1, rule2, rule3;
    pixel_class_t res;
    r = int'(r8);
    g = int'(g8);
    b = int'(b8);
    hc = int'(key_hue_center);
    hh = int'(key_hue_half);
    sc = int'(key_sat_center);
    sh = int'(key_sat_half);
    vc = int'(key_val_center);
    vh = int'(key_val_half);
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // red wins ties, then green
    if (d == 0) num = 0;
    else if (mx == r) num = 60 * (g - b) + ((g < b) ? 360 * d : 0);
    else if (mx == g) num = 60 * (b - r) + 120 * d;
    else num = 60 * (r - g) + 240 * d;
    hue = (d == 0) ? 0 : num / d;
    hue_zero = (num == 0);
    sat = (mx == 0) ? 0 : (100 * d) / mx;
    if (sat > 99) sat = 99;
    val = (100 * mx) / 255;
    if (val > 99) val = 99;
    // band limits are signed and never wrap round 360
    in_band = (hue >= hc - hh) && (hue <= hc + hh);
    rule1 = in_band && (sat >= sc - sh) && ((2 * mx > 255) || (val >= vc - vh));
    rule2 = (hue_zero || in_band) && (20 * d <= 13 * mx) && (5 * mx > 4 * 255);
    rule3 = in_band && (10 * d > 7 * mx) && (20 * mx > 3 * 255);
    res.is_bg = rule1 || rule2 || rule3;
    res.hue   = hue[hckc_pkg::HUE_W-1:0];
    res.sat   = sat[hckc_pkg::PCT_W-1:0];
    res.val   = val[hckc_pkg::PCT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // register writes, pixel predictions and result checks
  always @(posedge clk) begin
    if (rst) begin
      key_hue_center = hckc_pkg::HUE_CENTER_RST;
      key_hue_half   = hckc_pkg::HUE_HALFWIDTH_RST;
      key_sat_center = hckc_pkg::SAT_CENTER_RST;
      key_sat_half   = hckc_pkg::SAT_HALFWIDTH_RST;
      key_val_center = hckc_pkg::VAL_CENTER_RST;
      key_val_half   = hckc_pkg::VAL_HALFWIDTH_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hckc_pkg::REG_HUE_CENTER:    key_hue_center = cfg_data[hckc_pkg::HUE_W-1:0];
          hckc_pkg::REG_HUE_HALFWIDTH: key_hue_half   = cfg_data[hckc_pkg::HUE_W-1:0];
          hckc_pkg::REG_SAT_CENTER:    key_sat_center = cfg_data[hckc_pkg::PCT_W-1:0];
          hckc_pkg::REG_SAT_HALFWIDTH: key_sat_half   = cfg_data[hckc_pkg::PCT_W-1:0];
          hckc_pkg::REG_VAL_CENTER:    key_val_center = cfg_data[hckc_pkg::PCT_W-1:0];
          hckc_pkg::REG_VAL_HALFWIDTH: key_val_half   = cfg_data[hckc_pkg::PCT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (class_wr < TOTAL_PIXELS) begin
          class_mem[class_wr] = typed_on ? typed_class : classify_pixel(red, green, blue);
          class_wr++;
        end else begin
          report_mismatch("more pixel beats than planned, red", int'(red), 0);
        end
      end
      if (out_valid && out_ready) begin
        if (class_rd == class_wr) begin
          report_mismatch("result beat with nothing pending, hue_deg", int'(hue_deg), 0);
        end else begin
          want_class = class_mem[class_rd];
          class_rd++;
          pixels_seen++;
          if (want_class.is_bg) keyed_seen++;
          if (is_background !== want_class.is_bg)
            report_mismatch("is_background", int'(is_background), int'(want_class.is_bg));
          if (hue_deg !== want_class.hue)
            report_mismatch("hue_deg", int'(hue_deg), int'(want_class.hue));
          if (sat_pct !== want_class.sat)
            report_mismatch("sat_pct", int'(sat_pct), int'(want_class.sat));
          if (val_pct !== want_class.val)
            report_mismatch("val_pct", int'(val_pct), int'(want_class.val));
        end
      end
    end
  end

  // output back-pressure in bursts of random length
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      ready_hold <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hsv_chroma_key_classifier: mismatch");
      $finish;
    end
  end

  task automatic send_pixel(input logic [hckc_pkg::PIX_W-1:0] r,
                            input logic [hckc_pkg::PIX_W-1:0] g,
                            input logic [hckc_pkg::PIX_W-1:0] b, input logic with_typed,
                            input pixel_class_t typed);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    red         <= r;
    green       <= g;
    blue        <= b;
    typed_on    <= with_typed;
    typed_class <= typed;
    do @(posedge clk); while (!in_ready);
  endtask

  // valid is left high; the caller drops it once the last write is taken
  task automatic write_reg(input logic [hckc_pkg::IDX_W-1:0] idx,
                           input logic [hckc_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_bands(input logic [hckc_pkg::CFG_W-1:0] hc,
                            input logic [hckc_pkg::CFG_W-1:0] hh,
                            input logic [hckc_pkg::CFG_W-1:0] sc,
                            input logic [hckc_pkg::CFG_W-1:0] sh,
                            input logic [hckc_pkg::CFG_W-1:0] vc,
                            input logic [hckc_pkg::CFG_W-1:0] vh);
    write_reg(hckc_pkg::REG_HUE_CENTER, hc);
    write_reg(hckc_pkg::REG_HUE_HALFWIDTH, hh);
    write_reg(hckc_pkg::REG_SAT_CENTER, sc);
    write_reg(hckc_pkg::REG_SAT_HALFWIDTH, sh);
    write_reg(hckc_pkg::REG_VAL_CENTER, vc);
    write_reg(hckc_pkg::REG_VAL_HALFWIDTH, vh);
  endtask

  // let every pixel in flight come out before touching the bands
  task automatic drain_pipe;
    in_valid <= 1'b0;
    @(posedge clk);
    while (class_rd != class_wr) @(posedge clk);
    repeat (hckc_pkg::NSTG + 2) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [hckc_pkg::PIX_W-1:0] pr, pg, pb;
    int mode;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, dir_rows[i].typed,
                 dir_rows[i].want);

    for (int ph = 0; ph < BAND_PHASES; ph++) begin
      drain_pipe();
      case (ph)
        0: ;
        // band collapses to 0 degrees, floors at zero
        1: load_bands(9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
        // widest band, floors below zero
        2: load_bands(9'd374, 9'd360, 9'd99, 9'd101, 9'd99, 9'd101);
        // all-ones data (zero saturation halfwidth), masked to register width, plus dropped indexes
        3: begin
          write_reg(REG_SPARE_LO, 9'h000);
          load_bands(9'h1FF, 9'h1FF, 9'h1FF, 9'h000, 9'h1FF, 9'h1FF);
          write_reg(REG_SPARE_HI, 9'h1FF);
        end
        7: begin
          idle_on = 1'b0;
          load_bands(hckc_pkg::CFG_W'(hckc_pkg::HUE_CENTER_RST),
                     hckc_pkg::CFG_W'(hckc_pkg::HUE_HALFWIDTH_RST),
                     hckc_pkg::CFG_W'(hckc_pkg::SAT_CENTER_RST),
                     hckc_pkg::CFG_W'(hckc_pkg::SAT_HALFWIDTH_RST),
                     hckc_pkg::CFG_W'(hckc_pkg::VAL_CENTER_RST),
                     hckc_pkg::CFG_W'(hckc_pkg::VAL_HALFWIDTH_RST));
        end
        default: begin
          load_bands(hckc_pkg::CFG_W'($urandom_range(60, 180)),
                     hckc_pkg::CFG_W'($urandom_range(0, 60)),
                     hckc_pkg::CFG_W'($urandom_range(0, 99)),
                     hckc_pkg::CFG_W'($urandom_range(0, 101)),
                     hckc_pkg::CFG_W'($urandom_range(0, 99)),
                     hckc_pkg::CFG_W'($urandom_range(0, 101)));
          write_reg(hckc_pkg::IDX_W'($urandom_range(0, 7)),
                    hckc_pkg::CFG_W'($urandom_range(0, 511)));
        end
      endcase
      cfg_valid <= 1'b0;

      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        mode = $urandom_range(0, 9);
        if (mode <= 4) begin
          // green-dominant pixels that land around the keyed band
          pg = hckc_pkg::PIX_W'($urandom_range(40, 255));
          pr = hckc_pkg::PIX_W'($urandom_range(0, pg));
          pb = hckc_pkg::PIX_W'($urandom_range(0, pg));
        end else if (mode == 5) begin
          // grey, or red on top with green equal to blue
          pg = hckc_pkg::PIX_W'($urandom);
          pb = pg;
          pr = ($urandom_range(0, 1) != 0) ? pg : hckc_pkg::PIX_W'($urandom_range(pg, 255));
        end else if (mode == 6) begin
          pr = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ 8'($urandom_range(0, 1));
          pg = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ 8'($urandom_range(0, 1));
          pb = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ 8'($urandom_range(0, 1));
        end else begin
          pr = hckc_pkg::PIX_W'($urandom);
          pg = hckc_pkg::PIX_W'($urandom);
          pb = hckc_pkg::PIX_W'($urandom);
        end
        send_pixel(pr, pg, pb, 1'b0, '0);
      end
    end

    drain_pipe();
    $display("checked %0d pixels over %0d band settings, %0d keyed as background",
             pixels_seen, BAND_PHASES, keyed_seen);
    if (mismatches == 0)
      $display("hsv_chroma_key_classifier: match");
    else
      $display("hsv_chroma_key_classifier: mismatch");
    $finish;
  end

endmodule
